/* hw/rtl/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern search block.
package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 256;
	// cells per registered group of the match tree
	localparam int GROUP_SIZE = 16;
	localparam int CFG_W = 9;
	localparam int OFFSET_W = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam logic [OFFSET_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] entry_index;
		logic [7:0] entry_value;
		logic       entry_wild;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} rsp_t;

	typedef struct packed {
		logic wild;
		logic [7:0] value;
	} pat_entry_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic shift;
		logic rotate;
		logic write;
	} cell_ctrl_t;

	function automatic int addr_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

/* hw/rtl/wbps_cell.sv */
// One cell: a history byte, a pattern entry and their compare.
module wbps_cell import wbps_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       sel,
	input  pat_entry_t wr_entry,
	input  logic [7:0] hist_in,
	output logic [7:0] hist_out,
	input  pat_entry_t pat_in,
	output pat_entry_t pat_out,
	input  logic       active,
	output logic       ok
);

	logic [7:0] hist_q;
	pat_entry_t pat_q;

	// history moves one cell per search byte; pattern ring rotates or loads
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q <= hist_in;
		end
		if (ctrl.rotate) begin
			pat_q <= pat_in;
		end else if (ctrl.write && sel) begin
			pat_q <= wr_entry;
		end
	end

	assign hist_out = hist_q;
	assign pat_out  = pat_q;

	// cells past the pattern length always agree
	assign ok = !active || pat_q.wild || (pat_q.value == hist_q);

endmodule

/* hw/rtl/wbps_chain.sv */
// Row of compare cells with a registered group AND over their results.
module wbps_chain import wbps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int AW = addr_width(PATTERN_MAX)
) (
	input  logic          clk,
	input  cell_ctrl_t    ctrl,
	input  logic [AW-1:0] wr_addr,
	input  pat_entry_t    wr_entry,
	input  logic [7:0]    data_byte,
	input  logic [AW-1:0] len_last,
	output logic          all_ok
);

	localparam int NG = (PATTERN_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

	logic [7:0]              hist [PATTERN_MAX];
	pat_entry_t              pat  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]  ok;
	logic [NG*GROUP_SIZE-1:0] ok_pad;
	logic [NG-1:0]           grp_s2;

	genvar j;
	generate
		for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
			localparam int PREV = (j + PATTERN_MAX - 1) % PATTERN_MAX;
			localparam logic [AW-1:0] IDX = AW'(j);
			logic [7:0] hin;

			if (j == 0) begin : g_head
				assign hin = data_byte;
			end else begin : g_body
				assign hin = hist[j-1];
			end

			wbps_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.sel      (wr_addr == IDX),
				.wr_entry (wr_entry),
				.hist_in  (hin),
				.hist_out (hist[j]),
				.pat_in   (pat[PREV]),
				.pat_out  (pat[j]),
				.active   (IDX <= len_last),
				.ok       (ok[j])
			);
		end
	endgenerate

	// pad unused group slots with agreement
	always_comb begin
		ok_pad = '1;
		ok_pad[PATTERN_MAX-1:0] = ok;
	end

	// first level of the match tree, registered
	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_s2[g] <= &ok_pad[g*GROUP_SIZE +: GROUP_SIZE];
		end
	end

	assign all_ok = &grp_s2;

endmodule

/* hw/rtl/wildcard_byte_pattern_search.sv */
// A search byte's result passes the cell history registers, the registered group AND and
// the output register; rsp_stall can hold it before the output register. One load request
// per cycle while req_stall is low; after a search byte, no request is taken until its
// decision is made. A pattern_length write rotates the pattern ring one step per cycle,
// until it lines up with the new length, with requests stalled. Reset clears counters and
// flags, sets pattern_length to 1; pattern entries are undefined until loaded.
module wildcard_byte_pattern_search import wbps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW = addr_width(PATTERN_MAX);
	localparam int LW = ($clog2(PATTERN_MAX + 1) > CFG_W) ? $clog2(PATTERN_MAX + 1) : CFG_W;
	localparam int DW = ((AW > 8) ? AW : 8) + 1;
	localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);
	localparam logic [AW-1:0] ROT_TOP = AW'(PATTERN_MAX - 1);

	logic [LW-1:0]       len_q;
	logic [LW-1:0]       len_m1;
	logic [LW-1:0]       cfg_len;
	logic [AW-1:0]       len_last;
	logic [AW-1:0]       rot_q;
	logic                rotating;
	logic                accept;
	logic                is_search;
	logic                is_load;
	logic [DW-1:0]       idx_x;
	logic [DW-1:0]       diff;
	logic                in_range;
	logic [AW-1:0]       wr_addr;
	cell_ctrl_t          ctrl;
	pat_entry_t          wr_entry;
	logic                all_ok;
	logic                chk_s1_q;
	logic                chk_s2_q;
	logic                last_s1_q;
	logic                last_s2_q;
	logic                adv;
	logic                hit;
	logic                emit;
	logic [OFFSET_W-1:0] seen_q;
	logic [OFFSET_W-1:0] len_x;
	logic                match_done_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// effective length and ring alignment
	always_comb begin
		cfg_len  = LW'(cfg_wdata);
		len_m1   = len_q - LW'(1);
		len_last = len_m1[AW-1:0];
		rotating = (rot_q != len_last);
		len_x    = OFFSET_W'(len_q);
	end

	// request side
	assign req_stall = chk_s1_q || chk_s2_q || rotating;
	assign accept    = req_valid && !req_stall;
	assign is_search = (req_data.req_type == REQ_SEARCH);
	assign is_load   = (req_data.req_type == REQ_LOAD);

	// ring slot of a loaded entry: (rotation - index) mod PATTERN_MAX
	always_comb begin
		idx_x    = DW'(req_data.entry_index);
		in_range = (idx_x < DW'(PATTERN_MAX));
		diff     = DW'(rot_q) - idx_x;
		if (diff[DW-1]) begin
			diff = diff + DW'(PATTERN_MAX);
		end
		wr_addr = diff[AW-1:0];
	end

	always_comb begin
		ctrl.shift     = accept && is_search && !match_done_q;
		ctrl.rotate    = rotating;
		ctrl.write     = accept && is_load && in_range;
		wr_entry.wild  = req_data.entry_wild;
		wr_entry.value = req_data.entry_value;
	end

	wbps_chain #(
		.PATTERN_MAX (PATTERN_MAX),
		.AW          (AW)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.data_byte (req_data.data_byte),
		.len_last  (len_last),
		.all_ok    (all_ok)
	);

	// decision once the output slot is free
	assign adv  = chk_s2_q && (!rsp_valid_q || !rsp_stall);
	assign hit  = !match_done_q && all_ok && (seen_q >= len_x);
	assign emit = hit || (!match_done_q && last_s2_q);

	// length register and ring rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(1);
			rot_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_len == '0) begin
					len_q <= LW'(1);
				end else if (cfg_len > LEN_MAX) begin
					len_q <= LEN_MAX;
				end else begin
					len_q <= cfg_len;
				end
			end
			if (rotating) begin
				rot_q <= (rot_q == ROT_TOP) ? '0 : rot_q + AW'(1);
			end
		end
	end

	// compare sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1_q  <= 1'b0;
			chk_s2_q  <= 1'b0;
			last_s1_q <= 1'b0;
			last_s2_q <= 1'b0;
		end else begin
			chk_s1_q <= accept && is_search;
			if (accept) begin
				last_s1_q <= req_data.last_byte;
			end
			if (chk_s1_q) begin
				chk_s2_q  <= 1'b1;
				last_s2_q <= last_s1_q;
			end else if (adv) begin
				chk_s2_q <= 1'b0;
			end
		end
	end

	// region state: byte count and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			match_done_q <= 1'b0;
		end else begin
			if (ctrl.shift) begin
				seen_q <= (seen_q == COUNT_MAX) ? seen_q : seen_q + OFFSET_W'(1);
			end
			if (adv) begin
				if (last_s2_q) begin
					seen_q       <= '0;
					match_done_q <= 1'b0;
				end else if (hit) begin
					match_done_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rsp_q.found        <= hit;
			rsp_q.match_offset <= hit ? (seen_q - len_x) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	// a compare always moves on to its decision stage
	a_chk_advance: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1_q |=> chk_s2_q)
		else $error("compare did not reach decision stage");

	// only one search byte in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chk_s1_q, chk_s2_q}))
		else $error("two search bytes in flight");

	// a miss reports offset zero
	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.found) |-> (rsp_data.match_offset == '0))
		else $error("miss with nonzero offset");

	// nothing is taken while the ring is realigning
	a_no_req_rotating: assert property (@(posedge clk) disable iff (!arst_n)
		rotating |-> !ctrl.shift && !ctrl.write)
		else $error("request taken during rotation");
`endif

endmodule

/* dv/wbps_match_checker.sv */
// Checker for the wildcard byte pattern search: predicts every search outcome and compares.
module wbps_match_checker import wbps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req_data,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding,
	output int               hits,
	output int               misses
);

	pat_entry_t          pattern [PATTERN_MAX_DEF];
	logic [7:0]          recent [PATTERN_MAX_DEF]; // recent[0] is the newest byte
	logic [OFFSET_W-1:0] seen;                     // bytes of the current region
	logic                matched;                  // current region already matched
	logic [CFG_W-1:0]    length_reg;
	rsp_t                outcomes [$];
	int                  checked;

	// length in use: zero acts as one, anything past the store size is clamped
	function automatic int span();
		if (length_reg == '0)
			return 1;
		if (length_reg > PATTERN_MAX_DEF)
			return PATTERN_MAX_DEF;
		return int'(length_reg);
	endfunction

	// entry 0 lines up with the oldest byte of the window
	function automatic bit window_hit(input int n);
		for (int k = 0; k < n; k++) begin
			if (!pattern[k].wild && pattern[k].value != recent[n-1-k])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the search state by one request, queueing any outcome it causes
	task automatic apply_request(input req_t r);
		int   n;
		rsp_t o;
		if (r.req_type == REQ_LOAD) begin
			pattern[r.entry_index] = '{wild: r.entry_wild, value: r.entry_value};
			return;
		end
		if (!matched) begin
			n = span();
			for (int i = PATTERN_MAX_DEF - 1; i > 0; i--)
				recent[i] = recent[i-1];
			recent[0] = r.data_byte;
			if (seen != COUNT_MAX)
				seen++;
			if (seen >= OFFSET_W'(n) && window_hit(n)) begin
				matched = 1'b1;
				o.found = 1'b1;
				o.match_offset = seen - OFFSET_W'(n);
				outcomes.push_back(o);
			end else if (r.last_byte) begin
				o = '0;
				outcomes.push_back(o);
			end
		end
		// last byte closes the region whether or not it matched
		if (r.last_byte) begin
			seen = '0;
			matched = 1'b0;
		end
	endtask

	task automatic compare_outcome(input rsp_t got);
		rsp_t want;
		checked++;
		if (outcomes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing outstanding: found=%0b offset=%0d",
					checked, got.found, got.match_offset);
			return;
		end
		want = outcomes.pop_front();
		if (got.found !== want.found || got.match_offset !== want.match_offset) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: expected found=%0b offset=%0d, got found=%0b offset=%0d",
					checked, want.found, want.match_offset, got.found, got.match_offset);
		end
		if (want.found)
			hits++;
		else
			misses++;
	endtask

	// results are compared before the same edge's request is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX_DEF; i++) begin
				pattern[i] = '0;
				recent[i] = '0;
			end
			seen = '0;
			matched = 1'b0;
			length_reg = CFG_W'(1);
			outcomes.delete();
			checked = 0;
			mismatches = 0;
			hits = 0;
			misses = 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				compare_outcome(rsp_data);
			if (req_valid && !req_stall)
				apply_request(req_data);
			if (cfg_we)
				length_reg = cfg_wdata;
		end
		outstanding = outcomes.size();
	end

endmodule

/* dv/wildcard_byte_pattern_search_test.sv */
// Top of the wildcard byte pattern search testbench: clock, reset, stimulus and verdict.
module wildcard_byte_pattern_search_test;
	import wbps_pkg::*;

	localparam int ITEM_BUDGET = 1300;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	req_t             req_data = '0;
	logic             rsp_stall = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             req_stall;
	logic             rsp_valid;
	rsp_t             rsp_data;

	int mismatches;
	int outstanding;
	int hits;
	int misses;

	// stimulus copy of the pattern, used to plant matches
	logic [7:0] pat_value [PATTERN_MAX_DEF];
	logic       pat_wild [PATTERN_MAX_DEF];
	bit         loaded [PATTERN_MAX_DEF];
	int         cur_len = 1;

	int load_count;
	int byte_count;
	int regions_sent;
	int length_writes;
	bit gaps_allowed = 1'b1;
	bit final_stretch = 1'b0;

	always #5 clk = ~clk;

	wildcard_byte_pattern_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wbps_match_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.hits        (hits),
		.misses      (misses)
	);

	function automatic int usable_length(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > PATTERN_MAX_DEF)
			return PATTERN_MAX_DEF;
		return int'(v);
	endfunction

	// present one request, with an occasional gap before it, and wait until taken
	task automatic push_request(input req_t r);
		int gap;
		gap = (gaps_allowed && !final_stretch && $urandom_range(0, 5) == 0) ?
			$urandom_range(1, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic load_entry(input int idx, input logic [7:0] v, input logic w);
		req_t r;
		r.req_type = REQ_LOAD;
		r.entry_index = 8'(idx);
		r.entry_value = v;
		r.entry_wild = w;
		r.data_byte = 8'($urandom);
		r.last_byte = 1'($urandom);
		push_request(r);
		pat_value[idx] = v;
		pat_wild[idx] = w;
		loaded[idx] = 1'b1;
		load_count++;
	endtask

	task automatic search_byte(input logic [7:0] b, input logic fin);
		req_t r;
		r.req_type = REQ_SEARCH;
		r.entry_index = 8'($urandom);
		r.entry_value = 8'($urandom);
		r.entry_wild = 1'($urandom);
		r.data_byte = b;
		r.last_byte = fin;
		push_request(r);
		byte_count++;
		if (fin)
			regions_sent++;
	endtask

	// register writes only once the block has drained
	task automatic write_length(input logic [CFG_W-1:0] v);
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_len = usable_length(v);
		length_writes++;
	endtask

	// entries in use are written before the search bytes: all of them when fresh, else those never loaded
	task automatic fill_pattern(input bit fresh);
		for (int k = 0; k < cur_len; k++) begin
			if (fresh || !loaded[k])
				load_entry(k, 8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	// one region: planted match, noise, shorter than the pattern, or a single byte
	task automatic random_region();
		int         sel;
		int         nbytes;
		int         plant_at;
		int         k;
		logic [7:0] b;
		sel = $urandom_range(0, 9);
		plant_at = -1;
		if (sel < 6) begin
			nbytes = cur_len + $urandom_range(0, 12);
			plant_at = $urandom_range(0, nbytes - cur_len);
		end else if (sel < 8) begin
			nbytes = $urandom_range(1, cur_len + 12);
		end else if (sel == 8) begin
			nbytes = (cur_len > 1) ? $urandom_range(1, cur_len - 1) : 1;
		end else begin
			nbytes = 1;
		end
		for (int i = 0; i < nbytes; i++) begin
			k = i - plant_at;
			if (plant_at >= 0 && k >= 0 && k < cur_len)
				b = pat_wild[k] ? 8'($urandom) : pat_value[k];
			else if ($urandom_range(0, 1) == 0)
				b = pat_value[$urandom_range(0, cur_len - 1)]; // near misses
			else
				b = 8'($urandom);
			// pattern rewrite in the middle of a region
			if ($urandom_range(0, 39) == 0)
				load_entry($urandom_range(0, PATTERN_MAX_DEF - 1), 8'($urandom),
					$urandom_range(0, 3) == 0);
			search_byte(b, i == nbytes - 1);
		end
	endtask

	// response side stalls in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (gaps_allowed && !final_stretch && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any accepted request, result or register write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("wildcard_byte_pattern_search regression: fail");
		$finish;
	end

	initial begin : stimulus
		int               phase;
		int               pick;
		int               region_total;
		logic [CFG_W-1:0] new_len;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// single entry pattern after reset
		load_entry(0, 8'hFF, 1'b0);
		load_entry(255, 8'hFF, 1'b1);
		search_byte(8'h00, 1'b0);
		search_byte(8'hFF, 1'b1);
		search_byte(8'h00, 1'b1);
		// wildcard entry: match on the last byte, then bytes after a match
		load_entry(0, 8'h00, 1'b1);
		search_byte(8'hA5, 1'b1);
		search_byte(8'h3C, 1'b0);
		search_byte(8'h7E, 1'b0);
		search_byte(8'h81, 1'b1);
		// zero length acts as one
		write_length('0);
		search_byte(8'hFF, 1'b1);
		// three entries with a wildcard in the middle; short region first
		write_length(CFG_W'(3));
		load_entry(0, 8'h00, 1'b0);
		load_entry(1, 8'h5A, 1'b1);
		load_entry(2, 8'hFF, 1'b0);
		search_byte(8'h00, 1'b0);
		search_byte(8'hFF, 1'b1);
		search_byte(8'h11, 1'b0);
		search_byte(8'h00, 1'b0);
		search_byte(8'h5A, 1'b0);
		search_byte(8'hFF, 1'b0);
		search_byte(8'h22, 1'b1);
		search_byte(8'h00, 1'b0);
		search_byte(8'h12, 1'b0);
		search_byte(8'hFE, 1'b1);

		// random phases, each under one pattern length
		phase = 0;
		while (load_count + byte_count < ITEM_BUDGET) begin
			final_stretch = (load_count + byte_count) >= ITEM_BUDGET * 4 / 5;
			gaps_allowed = $urandom_range(0, 3) != 0;
			// sometimes leave a region open across the length change
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4)) search_byte(8'($urandom), 1'b0);
			pick = $urandom_range(0, 9);
			if (phase == 2)
				new_len = CFG_W'(PATTERN_MAX_DEF);
			else if (phase == 5)
				new_len = '1;
			else if (pick == 0)
				new_len = '0;
			else if (pick <= 3)
				new_len = CFG_W'($urandom_range(9, 40));
			else
				new_len = CFG_W'($urandom_range(1, 8));
			write_length(new_len);
			fill_pattern(cur_len <= 40 && $urandom_range(0, 1) == 1);
			region_total = (cur_len > 40) ? 1 : $urandom_range(1, 5);
			repeat (region_total) random_region();
			phase++;
		end

		// drain, then allow the pipeline to settle
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d pattern loads and %0d search bytes in %0d regions, %0d length writes",
			load_count, byte_count, regions_sent, length_writes);
		$display("outcomes: %0d matches, %0d regions without a match, %0d mismatches",
			hits, misses, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("wildcard_byte_pattern_search regression: pass");
		else
			$display("wildcard_byte_pattern_search regression: fail");
		$finish;
	end

endmodule
